// ===== rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg: shared codes for the point-to-segment distance block
// Configuration register indexes and the nearest-part result codes.
// ----------------------------------------------------------------------------
package psd_pkg;

    typedef logic [1:0] t_part;
    typedef logic [1:0] t_cfg_idx;

    localparam t_part PART_INTERIOR = 2'd0;
    localparam t_part PART_START    = 2'd1;
    localparam t_part PART_END      = 2'd2;

    localparam t_cfg_idx CFG_START_X = 2'd0;
    localparam t_cfg_idx CFG_START_Y = 2'd1;
    localparam t_cfg_idx CFG_END_X   = 2'd2;
    localparam t_cfg_idx CFG_END_Y   = 2'd3;

endpackage

// ===== rtl/psd_in_if.sv =====
// ----------------------------------------------------------------------------
// psd_in_if: query point channel
// Valid/ready channel that carries one query point per transfer.
// ----------------------------------------------------------------------------
interface psd_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/psd_out_if.sv =====
// ----------------------------------------------------------------------------
// psd_out_if: distance result channel
// Valid/ready channel that carries one distance result per transfer.
// ----------------------------------------------------------------------------
interface psd_out_if #(
    parameter int OUT_BITS = 25
);
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] distance;
    psd_pkg::t_part      nearest_part;
    logic [OUT_BITS-1:0] segment_length;

    modport source (output valid, output distance, output nearest_part,
                    output segment_length, input ready);
    modport sink   (input valid, input distance, input nearest_part,
                    input segment_length, output ready);
endinterface

// ===== rtl/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance: distance from a query point to a 2-D segment
// Endpoint tests on exact squared distances, perpendicular distance through
// a pipelined long divider and pipelined square roots.
// ----------------------------------------------------------------------------
// An input transfer passes stages 1 to 6, the restoring divider and the
// distance and length square roots, then the skid stage or the output.
// Throughput: one point per cycle while the skid stage is empty; the divider
// and both square roots retire one quotient or root bit per stage, so every
// stage holds its own item. Reset (synchronous, active low) clears all valid
// bits, the skid one too, and the four endpoint registers to zero.
// ----------------------------------------------------------------------------
module point_segment_distance #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  psd_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    psd_in_if.sink                i_pt,
    psd_out_if.source             o_res
);

    // D: coordinate difference, S: sum of two squares, QW: quotient and
    // radicand width (twice the output width), NW: shifted dividend.
    localparam int D  = COORD_BITS + 1;
    localparam int S  = 2 * D;
    localparam int OW = COORD_BITS + 1 + FRAC_BITS;
    localparam int QW = 2 * OW;
    localparam int NW = 2 * S + 2 * FRAC_BITS;

    // ------------------------------------------------------------------
    // Endpoint registers
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psd_pkg::CFG_START_X: r_sx <= i_cfg_data;
                psd_pkg::CFG_START_Y: r_sy <= i_cfg_data;
                psd_pkg::CFG_END_X:   r_ex <= i_cfg_data;
                psd_pkg::CFG_END_Y:   r_ey <= i_cfg_data;
                default:              r_sx <= r_sx;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances while the skid stage is empty.
    // ------------------------------------------------------------------
    logic en;
    logic r_skid_v;

    assign en         = !r_skid_v;
    assign i_pt.ready = en;

    logic in_xfer;
    assign in_xfer = i_pt.valid && i_pt.ready;

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences
    // ------------------------------------------------------------------
    logic signed [D-1:0] w_cx, w_cy, w_sx, w_sy, w_ex, w_ey;
    assign w_cx = D'(i_pt.point_x);
    assign w_cy = D'(i_pt.point_y);
    assign w_sx = D'(r_sx);
    assign w_sy = D'(r_sy);
    assign w_ex = D'(r_ex);
    assign w_ey = D'(r_ey);

    logic                r1_v;
    logic signed [D-1:0] r1_dx, r1_dy, r1_px, r1_py, r1_qx, r1_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= w_ex - w_sx;
            r1_dy <= w_ey - w_sy;
            r1_px <= w_cx - w_sx;
            r1_py <= w_cy - w_sy;
            r1_qx <= w_cx - w_ex;
            r1_qy <= w_cy - w_ey;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares and cross-product terms
    // ------------------------------------------------------------------
    logic                r2_v;
    logic signed [S-1:0] r2_dx2, r2_dy2, r2_px2, r2_py2, r2_qx2, r2_qy2;
    logic signed [S-1:0] r2_dxpy, r2_dypx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dx2  <= r1_dx * r1_dx;
            r2_dy2  <= r1_dy * r1_dy;
            r2_px2  <= r1_px * r1_px;
            r2_py2  <= r1_py * r1_py;
            r2_qx2  <= r1_qx * r1_qx;
            r2_qy2  <= r1_qy * r1_qy;
            r2_dxpy <= r1_dx * r1_py;
            r2_dypx <= r1_dy * r1_px;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared lengths and cross product
    // ------------------------------------------------------------------
    logic                r3_v;
    logic [S-1:0]        r3_ab2, r3_ac2, r3_bc2;
    logic signed [S:0]   r3_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ab2 <= $unsigned(r2_dx2) + $unsigned(r2_dy2);
            r3_ac2 <= $unsigned(r2_px2) + $unsigned(r2_py2);
            r3_bc2 <= $unsigned(r2_qx2) + $unsigned(r2_qy2);
            r3_cr  <= (S+1)'(r2_dxpy) - (S+1)'(r2_dypx);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the case; start endpoint is tested first, and a right
    // angle counts as not acute. A zero-length segment lands on the start.
    // ------------------------------------------------------------------
    logic [S:0]     w_ab_ac, w_ab_bc;
    psd_pkg::t_part w_part;
    logic [S:0]     w_cr_abs;

    assign w_ab_ac  = {1'b0, r3_ab2} + {1'b0, r3_ac2};
    assign w_ab_bc  = {1'b0, r3_ab2} + {1'b0, r3_bc2};
    assign w_cr_abs = r3_cr[S] ? $unsigned(-r3_cr) : $unsigned(r3_cr);

    always_comb begin
        if ({1'b0, r3_bc2} >= w_ab_ac) begin
            w_part = psd_pkg::PART_START;
        end else if ({1'b0, r3_ac2} >= w_ab_bc) begin
            w_part = psd_pkg::PART_END;
        end else begin
            w_part = psd_pkg::PART_INTERIOR;
        end
    end

    logic           r4_v;
    psd_pkg::t_part r4_part;
    logic [S-1:0]   r4_ab2, r4_ep, r4_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_part <= w_part;
            r4_ab2  <= r3_ab2;
            r4_ep   <= (w_part == psd_pkg::PART_START) ? r3_ac2 : r3_bc2;
            r4_cr   <= w_cr_abs[S-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of cross squared (halves of D bits)
    // ------------------------------------------------------------------
    logic           r5_v;
    psd_pkg::t_part r5_part;
    logic [S-1:0]   r5_ab2, r5_ep;
    logic [S-1:0]   r5_hh, r5_hl, r5_ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_part <= r4_part;
            r5_ab2  <= r4_ab2;
            r5_ep   <= r4_ep;
            r5_hh   <= r4_cr[S-1:D] * r4_cr[S-1:D];
            r5_hl   <= r4_cr[S-1:D] * r4_cr[D-1:0];
            r5_ll   <= r4_cr[D-1:0] * r4_cr[D-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sum cross squared, scale by the fraction bits and load the
    // divider. The quotient fits QW bits in the interior case, so the
    // top part of the dividend is already below the divisor.
    // ------------------------------------------------------------------
    logic [2*S-1:0] w_crsq;
    logic [NW-1:0]  w_num;

    assign w_crsq = ((2*S)'(r5_hh) << S) + ((2*S)'(r5_hl) << (D + 1))
                  + (2*S)'(r5_ll);
    assign w_num  = NW'(w_crsq) << (2 * FRAC_BITS);

    logic           r_dv_v [0:QW];
    psd_pkg::t_part r_dv_pt[0:QW];
    logic [S-1:0]   r_dv_d [0:QW];
    logic [S-1:0]   r_dv_ep[0:QW];
    logic [S-1:0]   r_dv_rm[0:QW];
    logic [QW-1:0]  r_dv_n [0:QW];
    logic [QW-1:0]  r_dv_q [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_pt[0] <= r5_part;
            r_dv_d[0]  <= r5_ab2;
            r_dv_ep[0] <= r5_ep;
            r_dv_rm[0] <= w_num[NW-1:QW];
            r_dv_n[0]  <= w_num[QW-1:0];
            r_dv_q[0]  <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [S:0] t;
        logic       ge;

        assign t  = {r_dv_rm[j], r_dv_n[j][QW-1]};
        assign ge = (t >= {1'b0, r_dv_d[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_pt[j+1] <= r_dv_pt[j];
                r_dv_d[j+1]  <= r_dv_d[j];
                r_dv_ep[j+1] <= r_dv_ep[j];
                r_dv_rm[j+1] <= ge ? S'(t - {1'b0, r_dv_d[j]}) : t[S-1:0];
                r_dv_n[j+1]  <= r_dv_n[j] << 1;
                r_dv_q[j+1]  <= {r_dv_q[j][QW-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Square roots: distance radicand and segment length radicand
    // ------------------------------------------------------------------
    logic [QW-1:0] w_rad, w_seg_rad;

    assign w_rad = (r_dv_pt[QW] == psd_pkg::PART_INTERIOR) ? r_dv_q[QW]
                 : (QW'(r_dv_ep[QW]) << (2 * FRAC_BITS));
    assign w_seg_rad = QW'(r_dv_d[QW]) << (2 * FRAC_BITS);

    logic [OW-1:0]  m_dist, m_seg;
    logic [2:0]     m_side;
    logic           m_seg_v;
    logic           m_v;
    psd_pkg::t_part m_part;

    psd_sqrt #(.W(OW), .SW(3)) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (w_rad),
        .i_side  ({r_dv_v[QW], r_dv_pt[QW]}),
        .o_root  (m_dist),
        .o_side  (m_side)
    );

    psd_sqrt #(.W(OW), .SW(1)) u_sqrt_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (w_seg_rad),
        .i_side  (r_dv_v[QW]),
        .o_root  (m_seg),
        .o_side  (m_seg_v)
    );

    assign m_v    = m_side[2];
    assign m_part = m_side[1:0];

    // ------------------------------------------------------------------
    // Skid stage: catch the last stage's result when the sink stalls, then
    // hold the pipe until that result is transferred.
    // ------------------------------------------------------------------
    logic [OW-1:0]  r_skid_dist, r_skid_seg;
    psd_pkg::t_part r_skid_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            r_skid_v <= !o_res.ready;
        end else begin
            r_skid_v <= m_v && !o_res.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_dist <= m_dist;
            r_skid_seg  <= m_seg;
            r_skid_part <= m_part;
        end
    end

    assign o_res.valid          = r_skid_v || m_v;
    assign o_res.distance       = r_skid_v ? r_skid_dist : m_dist;
    assign o_res.nearest_part   = r_skid_v ? r_skid_part : m_part;
    assign o_res.segment_length = r_skid_v ? r_skid_seg  : m_seg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // both root pipes show the same valid bit at their last stage
    a_lanes_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_v == m_seg_v)
        else $error("square root lanes out of step");

    // a held result stays held until it is transferred
    a_skid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_res.ready) |=> (r_skid_v && $stable(r_skid_dist)
                                        && $stable(r_skid_part)))
        else $error("skid result dropped before transfer");

    // the perpendicular case never comes from a zero-length segment
    a_interior_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.nearest_part == psd_pkg::PART_INTERIOR)
            |-> (o_res.segment_length != '0))
        else $error("interior result on a zero-length segment");

    // only the three defined part codes leave the block
    a_part_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.nearest_part == psd_pkg::PART_INTERIOR
                         || o_res.nearest_part == psd_pkg::PART_START
                         || o_res.nearest_part == psd_pkg::PART_END))
        else $error("undefined nearest part code");

endmodule

// ===== rtl/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt: pipelined integer square root
// Floor square root of a 2*W bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int W  = 25,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [2*W-1:0]  i_rad,
    input  logic [SW-1:0]   i_side,
    output logic [W-1:0]    o_root,
    output logic [SW-1:0]   o_side
);

    logic [W+1:0]   r_rem  [1:W];
    logic [W-1:0]   r_root [1:W];
    logic [2*W-1:0] r_rad  [1:W];
    logic [SW-1:0]  r_side [1:W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+1:0]   rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] rad_in;
        logic [SW-1:0]  side_in;
        logic [W+2:0]   t;
        logic [W+2:0]   trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign rad_in  = r_rad[k];
            assign side_in = r_side[k];
        end

        // bring down the next two radicand bits, try root*4+1
        assign t     = {rem_in[W:0], rad_in[2*W-1:2*W-2]};
        assign trial = (W+3)'({root_in, 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1] <= '0;
            end else if (i_en) begin
                r_side[k+1] <= side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? (W+2)'(t - trial) : t[W+1:0];
                r_root[k+1] <= (W)'({root_in, ge});
                r_rad[k+1]  <= rad_in << 2;
            end
        end
    end

    assign o_root = r_root[W];
    assign o_side = r_side[W];

endmodule
